>>> design/processor_port_with_floating_bits_unit_defines.svh
// Assertion macros for the processor port unit.
// Both sample on clk and are masked while rst_n is low.
`ifndef PROCESSOR_PORT_WITH_FLOATING_BITS_UNIT_DEFINES_SVH
`define PROCESSOR_PORT_WITH_FLOATING_BITS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PPFB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ppfb assertion failed");

`define PPFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppfb assertion failed");

`else

`define PPFB_ASSERT(label, prop)

`define PPFB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/ppfb_pkg.sv
`default_nettype none

package ppfb_pkg;

    typedef enum logic [1:0] {
        FUNC_RD_DATA = 2'd0,
        FUNC_RD_DIR  = 2'd1,
        FUNC_WR_DATA = 2'd2,
        FUNC_WR_DIR  = 2'd3
    } ppfb_func_t;

    localparam int CYCLE_W     = 64;
    localparam int DISCHARGE_W = 20;

    localparam logic [DISCHARGE_W-1:0] DISCHARGE_RESET = 20'd350000;

    // bit positions within the port
    localparam int CAP3_IDX  = 3;
    localparam int PLAY_IDX  = 4;
    localparam int MOTOR_IDX = 5;
    localparam int CAP6_IDX  = 6;
    localparam int CAP7_IDX  = 7;

    localparam logic [7:0] PULL_ONES = 8'h07;

    typedef struct packed {
        ppfb_func_t         func;
        logic [7:0]         wdata;
        logic [CYCLE_W-1:0] cycle_now;
        logic               play_key;
        logic [7:0]         video_bus_byte;
    } ppfb_req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       motor_update;
        logic       motor_on;
        logic       ram_write;
        logic       ram_addr;
        logic [7:0] ram_data;
        logic [7:0] port_value;
        logic [7:0] dir_value;
    } ppfb_rsp_t;

endpackage

`default_nettype wire

>>> design/ppfb_core.sv
`default_nettype none

`include "processor_port_with_floating_bits_unit_defines.svh"

module ppfb_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                fire,
    input  wire ppfb_pkg::ppfb_req_t                 item,
    input  wire logic [ppfb_pkg::DISCHARGE_W-1:0]    discharge_cycles,
    output ppfb_pkg::ppfb_rsp_t                      result
);
    import ppfb_pkg::*;

    logic [7:0]         data_reg, data_next;
    logic [7:0]         dir_reg, dir_next;
    logic               cap3_reg, cap3_next;   // bit 3 floats high once armed, until it is made an output again
    logic [CYCLE_W-1:0] dl6_reg, dl6_next;
    logic [CYCLE_W-1:0] dl7_reg, dl7_next;

    logic [CYCLE_W:0]   sum;
    logic [CYCLE_W-1:0] later;
    logic [7:0]         falling;
    logic [7:0]         pulls;

    always_comb
    begin
        sum   = {1'b0, item.cycle_now} + {{(CYCLE_W + 1 - DISCHARGE_W){1'b0}}, discharge_cycles};
        later = sum[CYCLE_W] ? {CYCLE_W{1'b1}} : sum[CYCLE_W-1:0];

        falling = dir_reg & ~item.wdata & data_reg;

        pulls            = PULL_ONES;
        pulls[CAP3_IDX]  = cap3_reg;
        pulls[PLAY_IDX]  = ~item.play_key;
        pulls[MOTOR_IDX] = 1'b0;
        pulls[CAP6_IDX]  = dl6_reg > item.cycle_now;
        pulls[CAP7_IDX]  = dl7_reg > item.cycle_now;

        data_next = data_reg;
        dir_next  = dir_reg;
        cap3_next = cap3_reg;
        dl6_next  = dl6_reg;
        dl7_next  = dl7_reg;

        result = '0;

        unique case (item.func)
            FUNC_RD_DATA:
            begin
                result.rdata = (data_reg & dir_reg) | (pulls & ~dir_reg);
            end
            FUNC_RD_DIR:
            begin
                result.rdata = dir_reg;
            end
            FUNC_WR_DATA:
            begin
                data_next = item.wdata;
                if (dir_reg[MOTOR_IDX])
                begin
                    result.motor_update = 1'b1;
                    result.motor_on     = ~item.wdata[MOTOR_IDX];
                end
                result.ram_write = 1'b1;
                result.ram_addr  = 1'b1;
                result.ram_data  = item.video_bus_byte;
            end
            FUNC_WR_DIR:
            begin
                dir_next = item.wdata;
                if (falling[CAP3_IDX])
                    cap3_next = 1'b1;
                else if (item.wdata[CAP3_IDX])
                    cap3_next = 1'b0;
                if (falling[CAP6_IDX])
                    dl6_next = later;
                else if (item.wdata[CAP6_IDX])
                    dl6_next = '0;
                if (falling[CAP7_IDX])
                    dl7_next = later;
                else if (item.wdata[CAP7_IDX])
                    dl7_next = '0;
                result.ram_write = 1'b1;
                result.ram_addr  = 1'b0;
                result.ram_data  = item.video_bus_byte;
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.port_value = data_next;
        result.dir_value  = dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
            dir_reg  <= '0;
            cap3_reg <= 1'b0;
            dl6_reg  <= '0;
            dl7_reg  <= '0;
        end
        else if (fire)
        begin
            data_reg <= data_next;
            dir_reg  <= dir_next;
            cap3_reg <= cap3_next;
            dl6_reg  <= dl6_next;
            dl7_reg  <= dl7_next;
        end
    end

    `PPFB_ASSERT_NEXT(a_idle_holds, !fire, $stable(data_reg) && $stable(dir_reg) && $stable(dl6_reg))
    `PPFB_ASSERT_NEXT(a_out6_clears, fire && item.func == FUNC_WR_DIR && item.wdata[CAP6_IDX], dl6_reg == '0)
    `PPFB_ASSERT_NEXT(a_out3_clears, fire && item.func == FUNC_WR_DIR && item.wdata[CAP3_IDX], !cap3_reg)

endmodule

`default_nettype wire

>>> design/ppfb_out_reg.sv
`default_nettype none

module ppfb_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire ppfb_pkg::ppfb_rsp_t load_item,
    output logic                     room,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output ppfb_pkg::ppfb_rsp_t      rsp_item
);
    import ppfb_pkg::*;

    logic      valid_reg;
    ppfb_rsp_t item_reg;

    // free when empty or when the held result leaves this cycle
    assign room      = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (room)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
            item_reg <= load_item;
    end

endmodule

`default_nettype wire

>>> design/processor_port_with_floating_bits_unit.sv
// Processor I/O port with floating input bits.
//
// Request channel (req_valid / req_stall / req_item): one port access per
// transfer, carrying the function code, write byte, cycle count, play key
// and last video bus byte. Response channel (rsp_valid / rsp_stall /
// rsp_item): exactly one result per access, in order.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes the
// discharge count; cfg_ready is always high. Write it only while idle.
//
// An access taken from the request channel is registered, evaluated
// against the port state and loaded into the response register when
// that register has room, which raises rsp_valid. Throughput is one access
// per cycle while rsp_stall is low, bounded by the single evaluation stage.
// A stalled response holds in its register; the input register keeps
// filling, and req_stall rises only when both registers are occupied.
// Reset clears data and direction registers, all discharge deadlines and
// both valid flags, and loads the discharge count with 350000.
`default_nettype none

module processor_port_with_floating_bits_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire ppfb_pkg::ppfb_req_t               req_item,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output ppfb_pkg::ppfb_rsp_t                    rsp_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ppfb_pkg::DISCHARGE_W-1:0]  cfg_data
);
    import ppfb_pkg::*;

    logic                   in_vld_reg, in_vld_next;
    ppfb_req_t              in_item_reg;
    logic [DISCHARGE_W-1:0] discharge_reg;

    logic      room;
    logic      fire;
    logic      req_take;
    ppfb_rsp_t result;

    // an access moves into the response register when there is room for it
    assign fire      = in_vld_reg && room;
    assign req_stall = in_vld_reg && !room;
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (req_take)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            discharge_reg <= DISCHARGE_RESET;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_valid && cfg_ready)
                discharge_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            in_item_reg <= req_item;
    end

    ppfb_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .item             (in_item_reg),
        .discharge_cycles (discharge_reg),
        .result           (result)
    );

    ppfb_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .load_item (result),
        .room      (room),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire

>>> bench/port_ledger_pkg.sv
`timescale 1ns / 100ps

package port_ledger_pkg;

    import ppfb_pkg::*;

    localparam logic [CYCLE_W-1:0] NEVER_CYCLE = '1;

    // Shadow of the port: predicts one response per accepted access and
    // keeps the predictions in arrival order until the responses come back.
    class port_ledger;

        logic [7:0]             data_q;
        logic [7:0]             dir_q;
        logic [CYCLE_W-1:0]     dl3;
        logic [CYCLE_W-1:0]     dl6;
        logic [CYCLE_W-1:0]     dl7;
        logic [DISCHARGE_W-1:0] discharge;
        ppfb_rsp_t              due_results[$];
        int unsigned            faults;
        int unsigned            matched;
        int unsigned            func_seen[4];

        function new();
            data_q    = '0;
            dir_q     = '0;
            dl3       = '0;
            dl6       = '0;
            dl7       = '0;
            discharge = DISCHARGE_RESET;
            faults    = 0;
            matched   = 0;
            foreach (func_seen[i])
                func_seen[i] = 0;
        endfunction

        function void set_discharge(logic [DISCHARGE_W-1:0] v);
            discharge = v;
        endfunction

        // level seen on the port pins for a data read
        function logic [7:0] pin_levels(logic [CYCLE_W-1:0] now, logic play);
            logic [7:0] pulls;
            pulls            = PULL_ONES;
            pulls[CAP3_IDX]  = (dl3 == NEVER_CYCLE) || (dl3 > now);
            pulls[CAP6_IDX]  = dl6 > now;
            pulls[CAP7_IDX]  = dl7 > now;
            pulls[PLAY_IDX]  = !play;
            return (data_q & dir_q) | (pulls & ~dir_q);
        endfunction

        function void load_direction(logic [7:0] v, logic [CYCLE_W-1:0] now);
            logic [7:0]         falling;
            logic [CYCLE_W:0]   sum;
            logic [CYCLE_W-1:0] later;
            falling = dir_q & ~v & data_q;
            sum     = {1'b0, now} + {{(CYCLE_W + 1 - DISCHARGE_W){1'b0}}, discharge};
            later   = sum[CYCLE_W] ? NEVER_CYCLE : sum[CYCLE_W-1:0];
            if (v[CAP3_IDX]) dl3 = '0;
            if (v[CAP6_IDX]) dl6 = '0;
            if (v[CAP7_IDX]) dl7 = '0;
            if (falling[CAP3_IDX]) dl3 = NEVER_CYCLE;
            if (falling[CAP6_IDX]) dl6 = later;
            if (falling[CAP7_IDX]) dl7 = later;
            dir_q = v;
        endfunction

        function void take_access(ppfb_req_t a);
            ppfb_rsp_t r;
            r = '0;
            case (a.func)
                FUNC_RD_DATA: r.rdata = pin_levels(a.cycle_now, a.play_key);
                FUNC_RD_DIR:  r.rdata = dir_q;
                FUNC_WR_DATA:
                begin
                    data_q = a.wdata;
                    if (dir_q[MOTOR_IDX])
                    begin
                        r.motor_update = 1'b1;
                        r.motor_on     = !a.wdata[MOTOR_IDX];
                    end
                    r.ram_write = 1'b1;
                    r.ram_addr  = 1'b1;
                    r.ram_data  = a.video_bus_byte;
                end
                default:
                begin
                    load_direction(a.wdata, a.cycle_now);
                    r.ram_write = 1'b1;
                    r.ram_addr  = 1'b0;
                    r.ram_data  = a.video_bus_byte;
                end
            endcase
            r.port_value = data_q;
            r.dir_value  = dir_q;
            due_results.push_back(r);
            func_seen[a.func]++;
        endfunction

        function void note_miss(string field, logic [7:0] want, logic [7:0] got);
            faults++;
            $display("%0t ns: %s mismatch, expected %02h, actual %02h",
                     $time, field, want, got);
        endfunction

        function void match_result(ppfb_rsp_t got);
            ppfb_rsp_t want;
            if (due_results.size() == 0)
            begin
                faults++;
                $display("%0t ns: response with nothing outstanding, expected none, actual %h",
                         $time, got);
                return;
            end
            want = due_results.pop_front();
            matched++;
            if (got.rdata !== want.rdata)
                note_miss("rdata", want.rdata, got.rdata);
            if (got.motor_update !== want.motor_update)
                note_miss("motor_update", want.motor_update, got.motor_update);
            if (got.motor_on !== want.motor_on)
                note_miss("motor_on", want.motor_on, got.motor_on);
            if (got.ram_write !== want.ram_write)
                note_miss("ram_write", want.ram_write, got.ram_write);
            if (got.ram_addr !== want.ram_addr)
                note_miss("ram_addr", want.ram_addr, got.ram_addr);
            if (got.ram_data !== want.ram_data)
                note_miss("ram_data", want.ram_data, got.ram_data);
            if (got.port_value !== want.port_value)
                note_miss("port_value", want.port_value, got.port_value);
            if (got.dir_value !== want.dir_value)
                note_miss("dir_value", want.dir_value, got.dir_value);
        endfunction

    endclass

endpackage

>>> bench/tb_processor_port_with_floating_bits_unit.sv
`timescale 1ns / 100ps

module tb_processor_port_with_floating_bits_unit;

    import ppfb_pkg::*;
    import port_ledger_pkg::*;

    // The limit is kept generous.
    localparam int unsigned CYCLE_LIMIT      = 400000;
    localparam int unsigned RANDOM_PER_PHASE = 260;
    localparam int unsigned PHASES           = 6;
    localparam logic [CYCLE_W-1:0] TOP_CYCLE = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    ppfb_req_t              req_item  = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    ppfb_rsp_t              rsp_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [DISCHARGE_W-1:0] cfg_data  = '0;

    // idle chances in percent, per side
    int unsigned send_idle_pct = 11;
    int unsigned recv_idle_pct = 53;

    int unsigned clock_count = 0;
    int unsigned settings_used = 1;

    // running machine cycle count handed to the port with each access
    logic [CYCLE_W-1:0] cycle_base = '0;

    port_ledger book;

    processor_port_with_floating_bits_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        clock_count <= clock_count + 1;
        if (clock_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still outstanding",
                     clock_count, book.due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Response side: check each transfer, then decide the stall for the
    // next edge. Exactly one NBA on rsp_stall per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                book.match_result(rsp_item);
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // One access: optional idle gap, then hold the item until the transfer.
    // Valid is left high on return so back-to-back items never drop it.
    task automatic send_access(input ppfb_req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        book.take_access(item);
    endtask

    task automatic send_fields(input ppfb_func_t f, input logic [7:0] wd,
                               input logic [CYCLE_W-1:0] now, input logic play,
                               input logic [7:0] vbyte);
        ppfb_req_t item;
        item.func           = f;
        item.wdata          = wd;
        item.cycle_now      = now;
        item.play_key       = play;
        item.video_bus_byte = vbyte;
        send_access(item);
    endtask

    // Drop valid and wait for every outstanding response, plus a little
    // slack for the input and response registers.
    task automatic settle();
        req_valid <= 1'b0;
        while (book.due_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_discharge(input logic [DISCHARGE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        book.set_discharge(v);
    endtask

    // Mostly a slowly rising count so the capacitor bits get to discharge;
    // now and then it steps back, jumps anywhere, or sits at the very top
    // where the deadline sum saturates.
    task automatic next_random_access(output ppfb_req_t item);
        int unsigned pick;
        int unsigned fpick;
        logic [7:0]  wd;
        pick = $urandom_range(0, 99);
        if (pick < 84)
            cycle_base = cycle_base + $urandom_range(0, 24);
        else if (pick < 89)
            cycle_base = cycle_base - $urandom_range(1, 40);
        else if (pick < 93)
            cycle_base = {$urandom(), $urandom()};
        else if (pick < 97)
            cycle_base = TOP_CYCLE - $urandom_range(0, 64);
        else
            cycle_base = TOP_CYCLE;

        wd    = 8'($urandom_range(0, 255));
        fpick = $urandom_range(0, 99);
        if (fpick < 40)
            item.func = FUNC_RD_DATA;
        else if (fpick < 50)
            item.func = FUNC_RD_DIR;
        else if (fpick < 70)
        begin
            item.func = FUNC_WR_DATA;
            // capacitor bits mostly high so a later release arms them
            if ($urandom_range(0, 1))
                wd = wd | 8'hC8;
        end
        else
        begin
            item.func = FUNC_WR_DIR;
            // randomly drive or release the capacitor bits, or leave them as drawn
            case ($urandom_range(0, 2))
                0: wd = wd | 8'hC8;
                1: wd = wd & 8'h37;
                default: ;
            endcase
        end
        item.wdata          = wd;
        item.cycle_now      = cycle_base;
        item.play_key       = 1'($urandom_range(0, 1));
        item.video_bus_byte = 8'($urandom_range(0, 255));
    endtask

    initial
    begin
        ppfb_req_t              item;
        logic [DISCHARGE_W-1:0] discharge_pick;

        book = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, discharge count at its reset value.
        // Reads straight out of reset, then the motor on and off.
        send_fields(FUNC_RD_DATA, 8'h00, 64'd0, 1'b0, 8'h00);
        send_fields(FUNC_RD_DIR, 8'hFF, TOP_CYCLE, 1'b1, 8'hFF);
        send_fields(FUNC_WR_DATA, 8'h20, 64'd1, 1'b0, 8'hFF);   // motor bit an input
        send_fields(FUNC_WR_DIR, 8'hFF, 64'd10, 1'b0, 8'h00);
        send_fields(FUNC_WR_DATA, 8'hDF, 64'd11, 1'b1, 8'hA5);  // motor on
        send_fields(FUNC_WR_DATA, 8'hFF, 64'd12, 1'b0, 8'h5A);  // motor off
        send_fields(FUNC_RD_DATA, 8'h00, 64'd20, 1'b1, 8'h00);
        // Release all bits with data high: bit 3 never discharges, bits 6/7
        // read 1 until the count reaches the deadline.
        send_fields(FUNC_WR_DIR, 8'h00, 64'd1000, 1'b0, 8'h3C);
        send_fields(FUNC_RD_DATA, 8'h00, 64'd350999, 1'b1, 8'h00);
        send_fields(FUNC_RD_DATA, 8'h00, 64'd351000, 1'b0, 8'h00);
        send_fields(FUNC_RD_DATA, 8'h00, TOP_CYCLE, 1'b1, 8'h00);
        // count running backwards
        send_fields(FUNC_RD_DATA, 8'h00, 64'd0, 1'b0, 8'h00);
        // Re-arm near the top of the count so the deadline saturates.
        send_fields(FUNC_WR_DIR, 8'hFF, TOP_CYCLE - 5, 1'b0, 8'h81);
        send_fields(FUNC_WR_DIR, 8'h00, TOP_CYCLE - 5, 1'b0, 8'h7E);
        send_fields(FUNC_RD_DATA, 8'h00, TOP_CYCLE - 1, 1'b0, 8'h00);
        send_fields(FUNC_RD_DATA, 8'h00, TOP_CYCLE, 1'b1, 8'h00);
        // Bits 3 and 6 become outputs, which clears their deadlines.
        send_fields(FUNC_WR_DIR, 8'h48, 64'd7, 1'b1, 8'h00);
        send_fields(FUNC_RD_DATA, 8'h00, 64'd8, 1'b0, 8'h00);
        // Release with data low: nothing armed.
        send_fields(FUNC_WR_DATA, 8'h00, 64'd9, 1'b0, 8'hFF);
        send_fields(FUNC_WR_DIR, 8'h00, 64'd9, 1'b1, 8'h00);
        send_fields(FUNC_RD_DATA, 8'h00, 64'd10, 1'b1, 8'h00);
        send_fields(FUNC_RD_DIR, 8'h00, 64'd11, 1'b0, 8'h00);

        // Random phases: two discharge settings per idling mode, the
        // extremes first.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 53;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0: discharge_pick = '0;
                1: discharge_pick = '1;
                2: discharge_pick = 20'd7;
                3: discharge_pick = 20'd40;
                4: discharge_pick = 20'd1000;
                default: discharge_pick = 20'($urandom_range(0, 2000));
            endcase
            settle();
            write_discharge(discharge_pick);
            settings_used++;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                next_random_access(item);
                send_access(item);
            end
        end

        settle();

        $display("covered %0d accesses: %0d data reads, %0d direction reads, %0d data writes,",
                 book.matched, book.func_seen[FUNC_RD_DATA], book.func_seen[FUNC_RD_DIR],
                 book.func_seen[FUNC_WR_DATA]);
        $display("%0d direction writes, across %0d discharge settings and three idling modes",
                 book.func_seen[FUNC_WR_DIR], settings_used);
        if (book.faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
